@@ design/assert_macros.svh @@
// Assertion macros shared by the save block cipher modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define SBSC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define SBSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/sbsc_pkg.sv @@
// Shared types and codes for the save block stream cipher
package sbsc_pkg;

   localparam int unsigned HDR_BYTES = 16;
   localparam int unsigned MAX_DATA  = 4;

   // report status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SHORT   = 2'd1;
   localparam logic [1:0] ST_HDR_EOF = 2'd2;
   localparam logic [1:0] ST_TRUNC   = 2'd3;

   // configuration register indexes
   localparam logic CSR_ENCRYPT    = 1'b0;
   localparam logic CSR_BIG_ENDIAN = 1'b1;

   // all results caused by one request: data bytes first, then an optional report
   typedef struct packed {
      logic [MAX_DATA-1:0][7:0] data;
      logic [2:0]               n_data;
      logic                     has_report;
      logic [31:0]              comp;
      logic [31:0]              expct;
      logic                     mismatch;
      logic [1:0]               status;
   } sbsc_run_type;

endpackage

@@ design/save_block_stream_cipher_core.sv @@
// Top level of the save block stream cipher
//
// Request channel (req_): one save file byte per request, req_end_of_file on
// the final byte. Each block is a 16-byte header (magic, size, checksum, seed)
// followed by payload whose full 32-bit words are XORed with a rolling key.
// Response channel (rsp_): data bytes in order, then an end-of-block checksum
// report (rsp_is_report); rsp_last_of_run marks the last response of a request.
// Configuration (csr_): index 0 encrypt mode, index 1 big endian; always ready.
// An accepted request waits in the input register, then is stepped through the
// cipher core into the run buffer; its first response is valid right after
// that step. Throughput: one request per cycle while rsp_ready is high and
// each request yields at most one response; a request yielding k responses
// (up to five) holds the run buffer until all k are taken, since the buffer
// drains one response per cycle while rsp_ready is high.
// Reset clears all cipher state and the configuration; the next byte starts a
// new file. When rsp_ready is low the run buffer holds and one more request
// waits in the input register before req_ready drops.
module save_block_stream_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_report,
   output logic [31:0] rsp_computed_checksum,
   output logic [31:0] rsp_expected_checksum,
   output logic        rsp_checksum_mismatch,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import sbsc_pkg::*;

   logic         in_vld_ff;
   logic [7:0]   in_byte_ff;
   logic         in_eof_ff;
   logic         encrypt_ff;
   logic         big_endian_ff;
   logic         buf_free;
   logic         advance;
   sbsc_run_type run;

   assign csr_ready = 1'b1;
   assign advance   = in_vld_ff && buf_free;
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         encrypt_ff    <= 1'b0;
         big_endian_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff  <= 1'b1;
            in_byte_ff <= req_in_byte;
            in_eof_ff  <= req_end_of_file;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_ENCRYPT:    encrypt_ff    <= csr_wdata;
               CSR_BIG_ENDIAN: big_endian_ff <= csr_wdata;
               default:        ;
            endcase
         end
      end
   end

   sbsc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .in_byte      (in_byte_ff),
      .end_of_file  (in_eof_ff),
      .encrypt_mode (encrypt_ff),
      .big_endian   (big_endian_ff),
      .run          (run)
   );

   sbsc_run_buf u_run_buf (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (advance),
      .run                   (run),
      .free                  (buf_free),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_is_report         (rsp_is_report),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_expected_checksum (rsp_expected_checksum),
      .rsp_checksum_mismatch (rsp_checksum_mismatch),
      .rsp_status            (rsp_status),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule

@@ design/sbsc_core.sv @@
// Per-byte cipher state and combinational step producing one run of results
module sbsc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_file,
   input  logic                 encrypt_mode,
   input  logic                 big_endian,
   output sbsc_pkg::sbsc_run_type run
);
   import sbsc_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_PASS    = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] ck_ff, ck_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] sum_ff, sum_in;
   logic [23:0] held_ff, held_in;
   logic [1:0]  hc_ff, hc_in;
   logic        rte_ff, rte_in;
   logic        clear;

   logic [31:0] word;
   logic [3:0][7:0] enc_byte;
   logic [3:0][7:0] cb;
   logic [31:0] fld_old, fld_new;
   logic [23:0] held_new;
   logic [31:0] left_dec;
   logic        ended;
   logic [9:0]  incr;

   assign word = {in_byte, held_ff};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         enc_byte[k] = word[8*k +: 8] ^
                       (big_endian ? key_ff[8*(3-k) +: 8] : key_ff[8*k +: 8]);
      end
   end

   assign held_new = held_ff | ({16'b0, in_byte} << {hc_ff, 3'b000});

   always_comb begin
      case (hdr_cnt_ff[3:2])
         2'd1:    fld_old = len_ff;
         2'd2:    fld_old = ck_ff;
         default: fld_old = key_ff;
      endcase
      if (hdr_cnt_ff[1:0] == 2'd0) begin
         fld_new = {24'b0, in_byte};
      end else if (big_endian) begin
         fld_new = {fld_old[23:0], in_byte};
      end else begin
         fld_new = fld_old | ({24'b0, in_byte} << {hdr_cnt_ff[1:0], 3'b000});
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      len_in     = len_ff;
      ck_in      = ck_ff;
      key_in     = key_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      held_in    = held_ff;
      hc_in      = hc_ff;
      rte_in     = rte_ff;
      clear      = 1'b0;
      run        = '0;
      cb         = '0;
      incr       = '0;
      left_dec   = left_ff;
      ended      = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            run.data[0] = in_byte;
            run.n_data  = 3'd1;
            case (hdr_cnt_ff[3:2])
               2'd1:    len_in = fld_new;
               2'd2:    ck_in  = fld_new;
               2'd3:    key_in = fld_new;
               default: ;
            endcase
            if (hdr_cnt_ff != 4'hF) begin
               hdr_cnt_in = hdr_cnt_ff + 4'd1;
               if (end_of_file) begin
                  run.has_report = 1'b1;
                  run.status     = ST_HDR_EOF;
                  clear          = 1'b1;
               end
            end else begin
               hdr_cnt_in = 4'd0;
               if (len_ff == 32'd0) begin
                  rte_in = 1'b1;
                  if (end_of_file) begin
                     run.has_report = 1'b1;
                     run.status     = ST_OK;
                     run.expct      = ck_ff;
                     clear          = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else if (len_ff < 32'(HDR_BYTES)) begin
                  run.has_report = 1'b1;
                  run.status     = ST_SHORT;
                  run.expct      = ck_ff;
                  if (end_of_file) begin
                     clear = 1'b1;
                  end else begin
                     phase_in = PH_PASS;
                  end
               end else if (len_ff == 32'(HDR_BYTES)) begin
                  run.has_report = 1'b1;
                  run.status     = ST_OK;
                  run.expct      = ck_ff;
                  clear          = 1'b1;
               end else begin
                  left_in = len_ff - 32'(HDR_BYTES);
                  if (end_of_file) begin
                     run.has_report = 1'b1;
                     run.status     = ST_TRUNC;
                     run.expct      = ck_ff;
                     clear          = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            if (hc_ff == 2'd3) begin
               run.data   = enc_byte;
               run.n_data = 3'd4;
               key_in     = (key_ff << 4) + (key_ff >> 4);
               held_in    = '0;
               hc_in      = 2'd0;
               for (int k = 0; k < 4; k++) begin
                  cb[k] = encrypt_mode ? enc_byte[k] : word[8*k +: 8];
               end
            end else begin
               held_in = held_new;
               hc_in   = hc_ff + 2'd1;
               for (int k = 0; k < 3; k++) begin
                  run.data[k] = held_new[8*k +: 8];
                  cb[k]       = held_new[8*k +: 8];
               end
            end
            if (!rte_ff && left_ff != 32'd0) begin
               left_dec = left_ff - 32'd1;
            end
            left_in = left_dec;
            ended   = rte_ff ? end_of_file : (left_dec == 32'd0);
            if (ended || end_of_file) begin
               if (hc_ff != 2'd3) begin
                  run.n_data = {1'b0, hc_ff} + 3'd1;
               end
            end
            for (int k = 0; k < 4; k++) begin
               if (3'(k) < run.n_data) begin
                  incr = incr + {2'b0, cb[k]};
               end
            end
            sum_in = sum_ff + {22'b0, incr};
            if (ended || end_of_file) begin
               run.has_report = 1'b1;
               run.status     = ended ? ST_OK : ST_TRUNC;
               run.comp       = sum_in;
               run.expct      = ck_ff;
               clear          = 1'b1;
            end
         end
         default: begin
            run.data[0] = in_byte;
            run.n_data  = 3'd1;
            if (end_of_file) begin
               clear = 1'b1;
            end
         end
      endcase

      run.mismatch = run.has_report && !encrypt_mode && run.status == ST_OK &&
                     run.comp != run.expct;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         len_ff     <= '0;
         ck_ff      <= '0;
         key_ff     <= '0;
         left_ff    <= '0;
         sum_ff     <= '0;
         held_ff    <= '0;
         hc_ff      <= '0;
         rte_ff     <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         len_ff     <= len_in;
         ck_ff      <= ck_in;
         key_ff     <= key_in;
         left_ff    <= left_in;
         sum_ff     <= sum_in;
         held_ff    <= held_in;
         hc_ff      <= hc_in;
         rte_ff     <= rte_in;
      end
   end

   `SBSC_ASSERT_IMP(a_hdr_cnt_idle, phase_ff != PH_HEADER, hdr_cnt_ff == 4'd0)
   `SBSC_ASSERT_IMP(a_pass_no_held, phase_ff == PH_PASS, hc_ff == 2'd0 && held_ff == '0)

endmodule

@@ design/sbsc_run_buf.sv @@
// Result run buffer: emits the results of one request, one per cycle while rsp_ready is high
module sbsc_run_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sbsc_pkg::sbsc_run_type run,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_report,
   output logic [31:0]            rsp_computed_checksum,
   output logic [31:0]            rsp_expected_checksum,
   output logic                   rsp_checksum_mismatch,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last_of_run
);
   import sbsc_pkg::*;
   `include "assert_macros.svh"

   sbsc_run_type run_ff;
   logic         busy_ff;
   logic [2:0]   idx_ff;
   logic [2:0]   total;
   logic         is_data;
   logic         last;
   logic         take;
   logic         run_nonempty;

   assign total        = run_ff.n_data + {2'b0, run_ff.has_report};
   assign last         = idx_ff == total - 3'd1;
   assign take         = busy_ff && rsp_ready;
   assign free         = !busy_ff || (take && last);
   assign is_data      = idx_ff < run_ff.n_data;
   assign run_nonempty = run.n_data != 3'd0 || run.has_report;

   assign rsp_valid             = busy_ff;
   assign rsp_out_byte          = is_data ? run_ff.data[idx_ff[1:0]] : 8'd0;
   assign rsp_is_report         = !is_data;
   assign rsp_computed_checksum = is_data ? 32'd0 : run_ff.comp;
   assign rsp_expected_checksum = is_data ? 32'd0 : run_ff.expct;
   assign rsp_checksum_mismatch = !is_data && run_ff.mismatch;
   assign rsp_status            = is_data ? ST_OK : run_ff.status;
   assign rsp_last_of_run       = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load && run_nonempty) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         run_ff  <= run;
      end else if (take) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   `SBSC_ASSERT_IMP(a_idx_range, busy_ff, idx_ff < total)
   `SBSC_ASSERT_IMP(a_report_last, busy_ff && rsp_is_report, rsp_last_of_run)
   `SBSC_ASSERT_NEXT(a_run_continues, take && !last, busy_ff)

endmodule
